// ===== design/vet_pkg.sv =====
package vet_pkg;

  localparam int CoordWidth = 32;
  localparam int TrigWidth  = 16;
  localparam int TrigFrac   = 14;
  localparam int ProdWidth  = CoordWidth + TrigWidth;
  localparam int SumWidth   = ProdWidth + 1;
  localparam int ShWidth    = SumWidth - TrigFrac;
  localparam int RegCount   = 7;
  localparam int AddrWidth  = 5;

  localparam logic [2:0] REG_OBJ_TRIG_X = 3'd0;
  localparam logic [2:0] REG_OBJ_TRIG_Y = 3'd1;
  localparam logic [2:0] REG_CAM_TRIG_Y = 3'd2;
  localparam logic [2:0] REG_CAM_TRIG_X = 3'd3;
  localparam logic [2:0] REG_OFFSET_X   = 3'd4;
  localparam logic [2:0] REG_OFFSET_Y   = 3'd5;
  localparam logic [2:0] REG_OFFSET_Z   = 3'd6;

  localparam logic [31:0] TRIG_IDENTITY = 32'd16384;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [TrigWidth-1:0]  trig_t;
  typedef logic signed [ProdWidth-1:0]  prod_t;

  // sign-extend both operands to the full product width
  function automatic prod_t mul_ct(input coord_t a, input trig_t b);
    mul_ct = prod_t'(a) * prod_t'(b);
  endfunction

  function automatic coord_t sat_coord(input logic signed [ShWidth-1:0] v);
    logic hi;
    logic lo;
    hi = !v[ShWidth-1] && (v[ShWidth-2:CoordWidth-1] != '0);
    lo = v[ShWidth-1] && (v[ShWidth-2:CoordWidth-1] != '1);
    if (hi) begin
      sat_coord = {1'b0, {(CoordWidth-1){1'b1}}};
    end else if (lo) begin
      sat_coord = {1'b1, {(CoordWidth-1){1'b0}}};
    end else begin
      sat_coord = v[CoordWidth-1:0];
    end
  endfunction

  // round to nearest, ties up, then clamp
  function automatic coord_t rot_round(input prod_t a, input prod_t b, input logic sub);
    logic signed [SumWidth-1:0] sum;
    sum = sub ? ($signed({a[ProdWidth-1], a}) - $signed({b[ProdWidth-1], b}))
              : ($signed({a[ProdWidth-1], a}) + $signed({b[ProdWidth-1], b}));
    sum = sum + $signed(SumWidth'(1) <<< (TrigFrac - 1));
    rot_round = sat_coord(sum[SumWidth-1:TrigFrac]);
  endfunction

  function automatic coord_t add_sat(input coord_t a, input coord_t b);
    logic signed [CoordWidth:0] sum;
    sum = $signed({a[CoordWidth-1], a}) + $signed({b[CoordWidth-1], b});
    if (sum[CoordWidth] != sum[CoordWidth-1]) begin
      add_sat = sum[CoordWidth] ? {1'b1, {(CoordWidth-1){1'b0}}}
                                : {1'b0, {(CoordWidth-1){1'b1}}};
    end else begin
      add_sat = sum[CoordWidth-1:0];
    end
  endfunction

endpackage

// ===== design/vertex_euler_transform_top.sv =====
// Model-space to camera-space vertex transform. One vertex beat per cycle
// enters and one result beat leaves per cycle while the pipeline is not
// stalled, through a nine-stage pipeline (a multiply stage and a
// round/saturate stage for each of the four rotations, plus one offset-add
// stage). The whole pipeline stalls only when the output register
// is full and m_tready is low. Coordinates are signed Q16.16, trig registers
// hold cosine in bits 15:0 and sine in bits 31:16 as signed Q1.14; every
// intermediate is rounded to nearest and saturated to 32 bits. Registers sit
// at byte addresses 0x00..0x18 and must be written only while the pipeline
// is empty.
module vertex_euler_transform_top
  import vet_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [95:0]          s_tdata,   // model_x, model_y, model_z
  input  logic                 s_tlast,   // final_vertex
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [95:0]          m_tdata,   // view_x, view_y, view_z
  output logic                 m_tlast,   // final_out
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic [31:0] obj_trig_x;
  logic [31:0] obj_trig_y;
  logic [31:0] cam_trig_y;
  logic [31:0] cam_trig_x;
  coord_t      offset_x;
  coord_t      offset_y;
  coord_t      offset_z;

  logic [2:0] reg_idx;
  logic       cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[AddrWidth-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      obj_trig_x <= TRIG_IDENTITY;
      obj_trig_y <= TRIG_IDENTITY;
      cam_trig_y <= TRIG_IDENTITY;
      cam_trig_x <= TRIG_IDENTITY;
      offset_x   <= '0;
      offset_y   <= '0;
      offset_z   <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_OBJ_TRIG_X: obj_trig_x <= pwdata;
        REG_OBJ_TRIG_Y: obj_trig_y <= pwdata;
        REG_CAM_TRIG_Y: cam_trig_y <= pwdata;
        REG_CAM_TRIG_X: cam_trig_x <= pwdata;
        REG_OFFSET_X:   offset_x   <= pwdata;
        REG_OFFSET_Y:   offset_y   <= pwdata;
        REG_OFFSET_Z:   offset_z   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_OBJ_TRIG_X: prdata = obj_trig_x;
      REG_OBJ_TRIG_Y: prdata = obj_trig_y;
      REG_CAM_TRIG_Y: prdata = cam_trig_y;
      REG_CAM_TRIG_X: prdata = cam_trig_x;
      REG_OFFSET_X:   prdata = offset_x;
      REG_OFFSET_Y:   prdata = offset_y;
      REG_OFFSET_Z:   prdata = offset_z;
      default:        prdata = '0;
    endcase
  end

  trig_t ox_c, ox_s, oy_c, oy_s, cy_c, cy_s, cx_c, cx_s;
  assign ox_c = obj_trig_x[15:0];
  assign ox_s = obj_trig_x[31:16];
  assign oy_c = obj_trig_y[15:0];
  assign oy_s = obj_trig_y[31:16];
  assign cy_c = cam_trig_y[15:0];
  assign cy_s = cam_trig_y[31:16];
  assign cx_c = cam_trig_x[15:0];
  assign cx_s = cam_trig_x[31:16];

  coord_t in_x, in_y, in_z;
  assign in_x = s_tdata[31:0];
  assign in_y = s_tdata[63:32];
  assign in_z = s_tdata[95:64];

  logic       adv;
  logic [9:1] vld;
  logic [9:1] lst;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[8:1], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lst <= {lst[8:1], s_tlast};
    end
  end

  // stage registers
  prod_t  p1_yc, p1_zs, p1_ys, p1_zc;
  coord_t x1;
  coord_t y2, z2, x2p;
  prod_t  p3_xc, p3_zs, p3_xs, p3_zc;
  coord_t y3p;
  coord_t x4, z4, y4p;
  coord_t x5, y5, z5;
  prod_t  p6_xc, p6_zs, p6_xs, p6_zc;
  coord_t y6p;
  coord_t vx7, z7, y7p;
  prod_t  p8_yc, p8_zs, p8_ys, p8_zc;
  coord_t vx8;
  coord_t vx9, vy9, vz9;

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_yc <= mul_ct(in_y, ox_c);
      p1_zs <= mul_ct(in_z, ox_s);
      p1_ys <= mul_ct(in_y, ox_s);
      p1_zc <= mul_ct(in_z, ox_c);
      x1    <= in_x;

      y2  <= rot_round(p1_yc, p1_zs, 1'b1);
      z2  <= rot_round(p1_ys, p1_zc, 1'b0);
      x2p <= x1;

      p3_xc <= mul_ct(x2p, oy_c);
      p3_zs <= mul_ct(z2, oy_s);
      p3_xs <= mul_ct(x2p, oy_s);
      p3_zc <= mul_ct(z2, oy_c);
      y3p   <= y2;

      x4  <= rot_round(p3_xc, p3_zs, 1'b1);
      z4  <= rot_round(p3_xs, p3_zc, 1'b0);
      y4p <= y3p;

      x5 <= add_sat(x4, offset_x);
      y5 <= add_sat(y4p, offset_y);
      z5 <= add_sat(z4, offset_z);

      p6_xc <= mul_ct(x5, cy_c);
      p6_zs <= mul_ct(z5, cy_s);
      p6_xs <= mul_ct(x5, cy_s);
      p6_zc <= mul_ct(z5, cy_c);
      y6p   <= y5;

      vx7 <= rot_round(p6_xc, p6_zs, 1'b1);
      z7  <= rot_round(p6_xs, p6_zc, 1'b0);
      y7p <= y6p;

      p8_yc <= mul_ct(y7p, cx_c);
      p8_zs <= mul_ct(z7, cx_s);
      p8_ys <= mul_ct(y7p, cx_s);
      p8_zc <= mul_ct(z7, cx_c);
      vx8   <= vx7;

      vx9 <= vx8;
      vy9 <= rot_round(p8_yc, p8_zs, 1'b1);
      vz9 <= rot_round(p8_ys, p8_zc, 1'b0);
    end
  end

  assign m_tvalid = vld[9];
  assign m_tlast  = lst[9];
  assign m_tdata  = {vz9, vy9, vx9};

`ifndef SYNTHESIS
  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("pipeline valid bits moved during a stall");

  a_out_fill: assert property (@(posedge clk) disable iff (rst)
    (adv && vld[8]) |=> m_tvalid)
    else $error("beat lost entering output register");

  a_in_capture: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (vld[1] && lst[1] == $past(s_tlast)))
    else $error("accepted beat not captured in first stage");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid && (vld == '0))
    else $error("pipeline not empty after reset");
`endif

endmodule

// ===== tb/vertex_euler_transform_top_test.sv =====
`timescale 1ns / 1ps

module vertex_euler_transform_top_test;
  import vet_pkg::*;

  localparam logic [2:0] REG_SPARE = 3'd7;
  localparam int PhaseCount = 10;
  localparam int RandomPerPhase = 54;
  localparam int QuietLimit = 1000;
  localparam int DrainCycles = 12;

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   last;
  } vertex_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [95:0]          s_tdata = '0;   // model_x, model_y, model_z
  logic                 s_tlast = 1'b0; // final_vertex
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [95:0]          m_tdata;        // view_x, view_y, view_z
  logic                 m_tlast;        // final_out
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  vertex_euler_transform_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  logic [31:0] shadow_regs [RegCount];
  vertex_t     vertex_queue[$];
  vertex_t     view_queue[$];
  vertex_t     sent_vertex;
  vertex_t     got_view;
  vertex_t     want_view;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          errors = 0;
  int          vertices_sent = 0;
  int          views_checked = 0;
  int          quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void turn_pair(input longint a, input longint b, input logic [31:0] trig,
                                    output longint p, output longint q);
    longint c;
    longint s;
    c = longint'(trig_t'(trig[15:0]));
    s = longint'(trig_t'(trig[31:16]));
    p = clamp32((a * c - b * s + (64'sd1 <<< (TrigFrac - 1))) >>> TrigFrac);
    q = clamp32((a * s + b * c + (64'sd1 <<< (TrigFrac - 1))) >>> TrigFrac);
  endfunction

  function automatic vertex_t camera_space(input vertex_t v);
    longint y1, z1, x2, z2, x3, y3, z3, vx, z4, vy, vz;
    vertex_t r;
    turn_pair(longint'(v.y), longint'(v.z), shadow_regs[REG_OBJ_TRIG_X], y1, z1);
    turn_pair(longint'(v.x), z1, shadow_regs[REG_OBJ_TRIG_Y], x2, z2);
    x3 = clamp32(x2 + longint'(coord_t'(shadow_regs[REG_OFFSET_X])));
    y3 = clamp32(y1 + longint'(coord_t'(shadow_regs[REG_OFFSET_Y])));
    z3 = clamp32(z2 + longint'(coord_t'(shadow_regs[REG_OFFSET_Z])));
    turn_pair(x3, z3, shadow_regs[REG_CAM_TRIG_Y], vx, z4);
    turn_pair(y3, z4, shadow_regs[REG_CAM_TRIG_X], vy, vz);
    r.x = vx[31:0];
    r.y = vy[31:0];
    r.z = vz[31:0];
    r.last = v.last;
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // drive and predict
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        sent_vertex.x = s_tdata[31:0];
        sent_vertex.y = s_tdata[63:32];
        sent_vertex.z = s_tdata[95:64];
        sent_vertex.last = s_tlast;
        view_queue.push_back(camera_space(sent_vertex));
        vertices_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (vertex_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
          sent_vertex = vertex_queue.pop_front();
          s_tdata <= {sent_vertex.z, sent_vertex.y, sent_vertex.x};
          s_tlast <= sent_vertex.last;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // check each result beat against the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_view.x = m_tdata[31:0];
      got_view.y = m_tdata[63:32];
      got_view.z = m_tdata[95:64];
      got_view.last = m_tlast;
      if (view_queue.size() == 0) begin
        flag_mismatch($sformatf("result beat with no vertex pending: %h", m_tdata));
      end else begin
        want_view = view_queue.pop_front();
        if (got_view.x !== want_view.x)
          flag_mismatch($sformatf("view_x got %0d want %0d", got_view.x, want_view.x));
        if (got_view.y !== want_view.y)
          flag_mismatch($sformatf("view_y got %0d want %0d", got_view.y, want_view.y));
        if (got_view.z !== want_view.z)
          flag_mismatch($sformatf("view_z got %0d want %0d", got_view.z, want_view.z));
        if (got_view.last !== want_view.last)
          flag_mismatch($sformatf("final_out got %b want %b", got_view.last, want_view.last));
        views_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("timeout: no beat for %0d cycles", QuietLimit);
        $display("vertex_euler_transform_top test failed");
        $finish;
      end
    end
  end

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx != REG_SPARE) shadow_regs[idx] = value;
  endtask

  task automatic wait_drained();
    while (vertex_queue.size() != 0 || s_tvalid) @(posedge clk);
    while (view_queue.size() != 0) @(posedge clk);
  endtask

  function automatic coord_t pick_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return coord_t'($urandom) >>> 12;
      2: begin
        case ($urandom_range(4))
          0: return 32'sh7fffffff;
          1: return 32'sh80000000;
          2: return 32'sd0;
          3: return -32'sd1;
          default: return 32'sd1;
        endcase
      end
      default: return coord_t'($urandom) >>> 6;
    endcase
  endfunction

  function automatic logic [31:0] pick_trig();
    trig_t c;
    trig_t s;
    trig_t t;
    case ($urandom_range(4))
      0: return $urandom;
      1: return TRIG_IDENTITY;
      default: begin
        case ($urandom_range(4))
          0: begin c = 16'sd16384; s = 16'sd0;    end
          1: begin c = 16'sd11585; s = 16'sd11585; end
          2: begin c = 16'sd14189; s = 16'sd8192;  end
          3: begin c = 16'sd15137; s = 16'sd6270;  end
          default: begin c = 16'sd16069; s = 16'sd3196; end
        endcase
        if ($urandom_range(1)) begin
          t = c;
          c = s;
          s = t;
        end
        if ($urandom_range(1)) c = -c;
        if ($urandom_range(1)) s = -s;
        return {s, c};
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_offset();
    case ($urandom_range(2))
      0: return $urandom;
      1: return coord_t'($urandom) >>> 8;
      default: return 32'd0;
    endcase
  endfunction

  task automatic load_setting(input int phase);
    logic [31:0] setting [RegCount];
    case (phase)
      1: begin
        setting[REG_OBJ_TRIG_X] = 32'h80008000;
        setting[REG_OBJ_TRIG_Y] = 32'h7fff7fff;
        setting[REG_CAM_TRIG_Y] = 32'h00002000;
        setting[REG_CAM_TRIG_X] = 32'hffffffff;
        setting[REG_OFFSET_X]   = 32'h7fffffff;
        setting[REG_OFFSET_Y]   = 32'h80000000;
        setting[REG_OFFSET_Z]   = 32'h7fffffff;
      end
      2: begin
        setting[REG_OBJ_TRIG_X] = 32'h00002000;
        setting[REG_OBJ_TRIG_Y] = 32'h20000000;
        setting[REG_CAM_TRIG_Y] = 32'h80000000;
        setting[REG_CAM_TRIG_X] = 32'h00008000;
        setting[REG_OFFSET_X]   = 32'h80000000;
        setting[REG_OFFSET_Y]   = 32'h00000000;
        setting[REG_OFFSET_Z]   = 32'h80000000;
      end
      3: begin
        setting[REG_OBJ_TRIG_X] = 32'h00000000;
        setting[REG_OBJ_TRIG_Y] = 32'h7fff7fff;
        setting[REG_CAM_TRIG_Y] = 32'h80008000;
        setting[REG_CAM_TRIG_X] = 32'hffffffff;
        setting[REG_OFFSET_X]   = 32'hffffffff;
        setting[REG_OFFSET_Y]   = 32'h00000001;
        setting[REG_OFFSET_Z]   = 32'h7fffffff;
      end
      default: begin
        setting[REG_OBJ_TRIG_X] = pick_trig();
        setting[REG_OBJ_TRIG_Y] = pick_trig();
        setting[REG_CAM_TRIG_Y] = pick_trig();
        setting[REG_CAM_TRIG_X] = pick_trig();
        setting[REG_OFFSET_X]   = pick_offset();
        setting[REG_OFFSET_Y]   = pick_offset();
        setting[REG_OFFSET_Z]   = pick_offset();
      end
    endcase
    for (int i = 0; i < RegCount; i++) apb_write(i[2:0], setting[i]);
    if (phase == 3 || phase == 7) apb_write(REG_SPARE, $urandom);
  endtask

  task automatic queue_directed();
    coord_t corner [10][3];
    vertex_t v;
    corner = '{
      '{32'sd0,          32'sd0,          32'sd0},
      '{32'sh7fffffff,   32'sh7fffffff,   32'sh7fffffff},
      '{32'sh80000000,   32'sh80000000,   32'sh80000000},
      '{-32'sd1,         -32'sd1,         -32'sd1},
      '{32'sd1,          -32'sd1,         32'sh00010000},
      '{32'sh7fffffff,   32'sh80000000,   32'sd0},
      '{32'sh80000000,   32'sh7fffffff,   -32'sd1},
      '{32'sh00010000,   32'sh00020000,   32'shffff0000},
      '{32'sh55555555,   32'shaaaaaaaa,   32'sh0f0f0f0f},
      '{32'shaaaaaaaa,   32'sh55555555,   32'shf0f0f0f0}
    };
    for (int i = 0; i < 10; i++) begin
      v.x = corner[i][0];
      v.y = corner[i][1];
      v.z = corner[i][2];
      v.last = i[0];
      vertex_queue.push_back(v);
    end
  endtask

  task automatic queue_random(input int count);
    vertex_t v;
    for (int i = 0; i < count; i++) begin
      v.x = pick_coord();
      v.y = pick_coord();
      v.z = pick_coord();
      v.last = ($urandom_range(7) == 0);
      vertex_queue.push_back(v);
    end
  endtask

  initial begin
    for (int i = 0; i < RegCount; i++) begin
      shadow_regs[i] = (i < REG_OFFSET_X) ? TRIG_IDENTITY : 32'd0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    for (int phase = 0; phase < PhaseCount; phase++) begin
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 46; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 46; end
        default: begin idle_pct = 15; stall_pct = 15; end
      endcase
      if (phase != 0) load_setting(phase);
      if (phase < 2) begin
        queue_directed();
      end else if (phase == 5) begin
        // hold the sender until the pipe is empty, then resume
        queue_random(RandomPerPhase / 2);
        wait_drained();
        queue_random(RandomPerPhase - RandomPerPhase / 2);
      end else begin
        queue_random(RandomPerPhase);
      end
      wait_drained();
    end
    repeat (DrainCycles) @(posedge clk);
    if (view_queue.size() != 0) flag_mismatch("results still pending at end of run");
    $display("Checked %0d of %0d vertices over %0d register settings,", views_checked,
             vertices_sent, PhaseCount);
    $display("with no gaps, sender gaps, receiver stalls and both mixed.");
    if (errors == 0) begin
      $display("vertex_euler_transform_top test passed");
    end else begin
      $display("vertex_euler_transform_top test failed");
    end
    $finish;
  end

endmodule
